// ----- design/rset_pkg.sv -----
// ----------------------------------------------------------------------------
// rset_pkg: shared constants for the randomised set table
// Capacity, derived widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package rset_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;
    localparam int RND_W    = 31;
    localparam int STEP_W   = $clog2(RND_W);

    // Operation codes (the high bit alone selects a draw)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_DRAW   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

endpackage

// ----- design/rset_mod.sv -----
// ----------------------------------------------------------------------------
// rset_mod: bit-serial modulo unit
// Reduces a 31-bit random number modulo the entry count, one bit per cycle.
// ----------------------------------------------------------------------------
module rset_mod
    import rset_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RND_W-1:0]  dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [ADDR_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    trial;

    // Shift in one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rnd_next  = rnd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, rnd_reg[RND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RND_W - 1);
            rnd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = CNT_W'(trial - {1'b0, divisor});
            else
                rem_next = CNT_W'(trial);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rnd_reg  <= rnd_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    // remainder is below the count, so it always fits an address
    assign remainder = rem_reg[ADDR_W-1:0];

endmodule

// ----- design/randomized_set_table.sv -----
// ----------------------------------------------------------------------------
// randomized_set_table: sorted set of signed values with random draw
// Insert, remove and draw over a single-port sorted table of 64 entries.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Insert and remove walk the table in
// a single-port memory, one read state and one compare or write state per
// entry: a linear search up to the insertion rank, then an entry-by-entry
// shift. A draw runs the bit-serial modulo unit and then reads one entry. The
// table contents are undefined after reset; only the count, the state and the
// response valid are cleared, so no clearing pass is needed. A finished result
// waits in the output register while the next request is taken.
module randomized_set_table
    import rset_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] value,
    input  logic [RND_W-1:0]         random_draw,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic                     success,
    output logic signed [DATA_W-1:0] element,
    output logic [1:0]               status
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SRCH_RD   = 4'd1;
    localparam logic [3:0] S_SRCH_CMP  = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_INS_RD    = 4'd4;
    localparam logic [3:0] S_INS_WR    = 4'd5;
    localparam logic [3:0] S_REM_RD    = 4'd6;
    localparam logic [3:0] S_REM_WR    = 4'd7;
    localparam logic [3:0] S_DIV       = 4'd8;
    localparam logic [3:0] S_DRAW_RD   = 4'd9;
    localparam logic [3:0] S_DRAW_DATA = 4'd10;
    localparam logic [3:0] S_FINISH    = 4'd11;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic                     found_reg, found_next;
    logic [1:0]               op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic                     res_success_reg, res_success_next;
    logic signed [DATA_W-1:0] res_element_reg, res_element_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     success_reg;
    logic signed [DATA_W-1:0] element_reg;
    logic [1:0]               status_reg;

    logic signed [DATA_W-1:0] entries_reg [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]        mem_rd_addr, mem_wr_addr;
    logic signed [DATA_W-1:0] mem_wr_data;

    logic                     accept, out_load, div_start, div_done;
    logic [ADDR_W-1:0]        div_rem;
    logic [CNT_W-1:0]         idx_dec, idx_inc;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;

    rset_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (random_draw),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        res_success_next = res_success_reg;
        res_element_next = res_element_reg;
        res_status_next  = res_status_reg;
        div_start        = 1'b0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = idx_reg[ADDR_W-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_reg[ADDR_W-1:0];
        mem_wr_data      = rd_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_success_next = 1'b0;
                    res_element_next = '0;
                    res_status_next  = ST_OK;
                    idx_next         = '0;
                    if (opcode[1])
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else
                        state_next = S_SRCH_RD;
                end
            end
            // Linear search for the first entry not below the value
            S_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    found_next = 1'b0;
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_data_reg < val_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    found_next = (rd_data_reg == val_reg);
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (found_reg)
                    begin
                        res_status_next = ST_DUPLICATE;
                        state_next      = S_FINISH;
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        res_status_next = ST_DUPLICATE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        idx_next   = pos_reg;
                        state_next = S_REM_RD;
                    end
                end
            end
            // Insert: move entries up one place from the top down to the rank
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    mem_wr_en        = 1'b1;
                    mem_wr_data      = val_reg;
                    count_next       = count_reg + 1'b1;
                    res_success_next = 1'b1;
                    state_next       = S_FINISH;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_dec[ADDR_W-1:0];
                    state_next  = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_wr_en  = 1'b1;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end
            // Remove: move entries down one place from the rank upward
            S_REM_RD:
            begin
                if (idx_inc == count_reg)
                begin
                    count_next       = count_reg - 1'b1;
                    res_success_next = 1'b1;
                    state_next       = S_FINISH;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_inc[ADDR_W-1:0];
                    state_next  = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                mem_wr_en  = 1'b1;
                idx_next   = idx_inc;
                state_next = S_REM_RD;
            end
            // Draw: wait for the modulo, then fetch the entry at that rank
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DRAW_RD;
            end
            S_DRAW_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = div_rem;
                state_next  = S_DRAW_DATA;
            end
            S_DRAW_DATA:
            begin
                res_element_next = rd_data_reg;
                res_success_next = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once the transaction is taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        found_reg       <= found_next;
        res_success_reg <= res_success_next;
        res_element_reg <= res_element_next;
        res_status_reg  <= res_status_next;
        if (accept)
        begin
            op_reg  <= opcode;
            val_reg <= value;
        end
        if (out_load)
        begin
            success_reg <= res_success_reg;
            element_reg <= res_element_reg;
            status_reg  <= res_status_reg;
        end
    end

    // Sorted entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            entries_reg[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= entries_reg[mem_rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign success   = success_reg;
    assign element   = element_reg;
    assign status    = status_reg;

endmodule

// ----- design/rset_check.sv -----
// ----------------------------------------------------------------------------
// rset_check: port-level checks for the randomised set table
// Result consistency and handshake behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module rset_check
    import rset_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic                     success,
    input logic signed [DATA_W-1:0] element,
    input logic [1:0]               status
);

    // A stalled result transaction holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(success)
            && $stable(element) && $stable(status))
        else $error("result changed while stalled");

    // Success goes together with an ok status
    a_success_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (success == (status == ST_OK)))
        else $error("success and status disagree");

    // Element is zero whenever the transaction did not succeed
    a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !success |-> element == '0)
        else $error("element non-zero on failed transaction");

    // Ready is always low in the cycle after a request is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready straight after an accepted request");

endmodule

bind randomized_set_table rset_check u_rset_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .success   (success),
    .element   (element),
    .status    (status)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the randomised set table
// Sends insert, remove and draw transactions with random idling on both
// channels; a scoreboard keeps its own sorted copy of the set and checks
// every response field against it.
// ----------------------------------------------------------------------------
module tb_top;
    import rset_pkg::*;

    // Unused opcode, decoded by its high bit as a draw
    localparam logic [1:0] OP_DRAW_ALT = 2'd3;

    localparam int RANDOM_ITEMS  = 1500;
    localparam int IDLE_PCT      = 19;
    localparam int POOL_SIZE     = 96;
    localparam int DRAIN_CYCLES  = 20000;
    localparam int SETTLE_CYCLES = 150;

    typedef struct packed {
        logic                     success;
        logic signed [DATA_W-1:0] element;
        logic [1:0]               status;
    } rset_rsp_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted copy of the set and the queue of expected responses
    // ------------------------------------------------------------------------
    class rset_scoreboard;
        logic signed [DATA_W-1:0] members_q[$];
        rset_rsp_t                expected_rsp_q[$];
        int                       errors;
        int                       checked;
        int                       peak_count;
        int                       status_seen[4];

        function new();
            errors     = 0;
            checked    = 0;
            peak_count = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // Apply one transaction to the local set and work out its response
        function rset_rsp_t predict_response(logic [1:0] op,
                                             logic signed [DATA_W-1:0] val,
                                             logic [RND_W-1:0] rnd);
            rset_rsp_t   rsp;
            int unsigned cnt;
            int unsigned pos;
            bit          found;
            rsp   = '0;
            cnt   = members_q.size();
            found = 1'b0;
            if (op[1])
            begin
                if (cnt == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    rsp.success = 1'b1;
                    rsp.element = members_q[{1'b0, rnd} % cnt];
                    rsp.status  = ST_OK;
                end
            end
            else
            begin
                // lower rank: first entry not below the value
                pos = 0;
                while (pos < cnt && members_q[pos] < val)
                    pos++;
                if (pos < cnt)
                    found = (members_q[pos] == val);
                if (op == OP_INSERT)
                begin
                    // presence is checked before fullness
                    if (found)
                        rsp.status = ST_DUPLICATE;
                    else if (cnt >= CAPACITY)
                        rsp.status = ST_FULL;
                    else
                    begin
                        members_q.insert(pos, val);
                        rsp.success = 1'b1;
                        rsp.status  = ST_OK;
                    end
                end
                else
                begin
                    if (!found)
                        rsp.status = ST_DUPLICATE;
                    else
                    begin
                        members_q.delete(pos);
                        rsp.success = 1'b1;
                        rsp.status  = ST_OK;
                    end
                end
            end
            if (members_q.size() > peak_count)
                peak_count = members_q.size();
            status_seen[rsp.status]++;
            return rsp;
        endfunction

        function void note_request(logic [1:0] op, logic signed [DATA_W-1:0] val,
                                   logic [RND_W-1:0] rnd);
            rset_rsp_t rsp;
            rsp = predict_response(op, val, rnd);
            expected_rsp_q.insert(expected_rsp_q.size(), rsp);
        endfunction

        function void check_result(logic s, logic signed [DATA_W-1:0] e, logic [1:0] st);
            rset_rsp_t exp_rsp;
            if (expected_rsp_q.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                errors++;
                return;
            end
            exp_rsp = expected_rsp_q.pop_front();
            checked++;
            if (s !== exp_rsp.success)
            begin
                $error("success: expected %0d, actual %0d", exp_rsp.success, s);
                errors++;
            end
            if (e !== exp_rsp.element)
            begin
                $error("element: expected %0d, actual %0d", exp_rsp.element, e);
                errors++;
            end
            if (st !== exp_rsp.status)
            begin
                $error("status: expected %0d, actual %0d", exp_rsp.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction

        // A present value, for removes that should hit
        function logic signed [DATA_W-1:0] any_member();
            if (members_q.size() == 0)
                return $urandom;
            return members_q[$urandom_range(0, members_q.size() - 1)];
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     req_valid   = 1'b0;
    logic                     req_ready;
    logic [1:0]               opcode      = OP_INSERT;
    logic signed [DATA_W-1:0] value       = '0;
    logic [RND_W-1:0]         random_draw = '0;
    logic                     rsp_valid;
    logic                     rsp_ready   = 1'b0;
    logic                     success;
    logic signed [DATA_W-1:0] element;
    logic [1:0]               status;

    logic                     calm        = 1'b0;
    logic signed [DATA_W-1:0] value_pool[POOL_SIZE];
    rset_scoreboard           sb;

    always #5 clk = ~clk;

    randomized_set_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .opcode      (opcode),
        .value       (value),
        .random_draw (random_draw),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .success     (success),
        .element     (element),
        .status      (status)
    );

    // Response back-pressure, none during the calm stretch
    always @(posedge clk)
    begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: both channels sampled at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_result(success, element, status);
            if (req_valid && req_ready)
                sb.note_request(opcode, value, random_draw);
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: optional idle gap, then hold the transaction until taken
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                                input logic [RND_W-1:0] rnd);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 140)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        opcode      <= op;
        value       <= val;
        random_draw <= rnd;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [RND_W-1:0] pick_draw();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return RND_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mix_mode_t                mode;
        int                       item;
        int                       phase_len;
        int                       roll;
        int                       wait_cycles;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;

        sb = new();
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sh0000_0001;
        value_pool[5] = 32'sh8000_0001;
        value_pool[6] = 32'sh7FFF_FFFE;
        for (int i = 7; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, duplicates, absent removes, draw ranks
        send_request(OP_DRAW, 32'sd0, '0);
        send_request(OP_DRAW_ALT, 32'sd0, '1);
        send_request(OP_REMOVE, 32'sd5, '0);
        send_request(OP_INSERT, 32'sd0, '0);
        send_request(OP_INSERT, 32'sh8000_0000, '0);
        send_request(OP_INSERT, 32'sh7FFF_FFFF, '0);
        send_request(OP_INSERT, -32'sd1, '0);
        send_request(OP_INSERT, 32'sd1, '0);
        send_request(OP_INSERT, 32'sh8000_0000, '1);
        send_request(OP_INSERT, 32'sh7FFF_FFFF, '1);
        send_request(OP_DRAW, 32'sh7FFF_FFFF, '0);
        send_request(OP_DRAW, 32'sh8000_0000, '1);
        send_request(OP_DRAW_ALT, 32'sd0, 31'd4);
        send_request(OP_REMOVE, 32'sd2, '0);
        send_request(OP_REMOVE, 32'sh7FFF_FFFF, '0);
        send_request(OP_REMOVE, 32'sh8000_0000, '0);
        send_request(OP_REMOVE, 32'sd0, '0);
        send_request(OP_INSERT, 32'sh5555_5555, 31'h2AAA_AAAA);
        send_request(OP_INSERT, 32'shAAAA_AAAA, 31'h5555_5555);
        send_request(OP_DRAW, 32'sd0, 31'h5555_5555);
        send_request(OP_DRAW, 32'sd0, 31'h2AAA_AAAA);

        // Random phases: filling, draining and mixed traffic
        item = 0;
        while (item < RANDOM_ITEMS)
        begin
            mode      = mix_mode_t'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 160);
            for (int n = 0; n < phase_len && item < RANDOM_ITEMS; n++)
            begin
                calm <= (item >= 700 && item < 1000);
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:
                        op = (roll < 80) ? OP_INSERT : (roll < 90) ? OP_REMOVE : OP_DRAW;
                    MODE_DRAIN:
                        op = (roll < 75) ? OP_REMOVE : (roll < 85) ? OP_INSERT : OP_DRAW;
                    default:
                        op = (roll < 34) ? OP_INSERT : (roll < 67) ? OP_REMOVE :
                             (roll < 96) ? OP_DRAW : OP_DRAW_ALT;
                endcase
                if (op == OP_REMOVE && $urandom_range(0, 1) == 1)
                    val = sb.any_member();
                else
                    val = pick_value();
                send_request(op, val, pick_draw());
                item++;
            end
        end
        req_valid <= 1'b0;
        calm      <= 1'b0;

        // Drain outstanding responses, then let the block settle
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < DRAIN_CYCLES)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected responses never arrived", sb.pending());
            sb.errors++;
        end

        $display("Checked %0d responses; peak occupancy %0d of %0d entries.",
                 sb.checked, sb.peak_count, CAPACITY);
        $display("Status counts: ok %0d, present/absent %0d, full %0d, empty %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_DUPLICATE],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rset_pkg.sv
design/rset_mod.sv
design/randomized_set_table.sv
design/rset_check.sv
sim/tb_top.sv
